// ===== rtl/hidrb_pkg.sv =====
// shared types and constants of the hid report builder
// no dependencies; imported by every module of the block

package hidrb_pkg;

    // event kinds
    localparam logic [2:0] KIND_KEY    = 3'd0;
    localparam logic [2:0] KIND_MOTION = 3'd1;
    localparam logic [2:0] KIND_BUTTON = 3'd2;
    localparam logic [2:0] KIND_WHEEL  = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;

    // modifier usage codes
    localparam logic [7:0] MOD_FIRST = 8'd224;
    localparam logic [7:0] MOD_LAST  = 8'd231;

    // button codes
    localparam logic [7:0] BTN_LEFT   = 8'd1;
    localparam logic [7:0] BTN_MIDDLE = 8'd2;
    localparam logic [7:0] BTN_RIGHT  = 8'd3;

    localparam logic RPT_KBD   = 1'b0;
    localparam logic RPT_MOUSE = 1'b1;

    localparam int         KBD_SLOTS      = 6;
    localparam logic [7:0] ROLLOVER_CODE  = 8'd1;
    localparam logic [7:0] INTERVAL_RESET = 8'd8;
    localparam logic [7:0] TICK_MAX       = 8'd255;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         scancode;
        logic               pressed;
        logic signed [15:0] motion_x;
        logic signed [15:0] motion_y;
        logic [7:0]         button;
        logic signed [15:0] wheel_y;
    } t_in;

    typedef struct packed {
        logic       report_type;
        logic       last;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
        logic [7:0] byte6;
        logic [7:0] byte7;
    } t_out;

    typedef logic [KBD_SLOTS-1:0][7:0] t_slots;

    typedef struct packed {
        logic       start;
        logic       clear;
        logic       press;
        logic       hit_en;
        logic [7:0] code;
    } t_scan_ctl;

    typedef struct packed {
        logic done;
        logic rollover;
    } t_scan_sts;

    typedef struct packed {
        logic       motion;
        logic       button;
        logic       wheel;
        logic       tick;
        logic       clear;
        logic       emit;
        logic       press;
        logic [7:0] btn;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] dw;
    } t_mouse_ctl;

    typedef struct packed {
        logic       want;
        logic [2:0] buttons;
        logic [7:0] sum_x;
        logic [7:0] sum_y;
        logic [7:0] sum_w;
    } t_mouse_sts;

endpackage

// ===== rtl/hidrb_key_scan.sv =====
// held-key bitmap kept as a circular shift register, one code per cycle
// collects the lowest held codes into report slots; uses hidrb_pkg

module hidrb_key_scan #(
    parameter int KEY_CODES   = 256,
    parameter int REPORT_KEYS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hidrb_pkg::t_scan_ctl  i_ctl,
    output hidrb_pkg::t_scan_sts  o_sts,
    output hidrb_pkg::t_slots     o_slots
);
    import hidrb_pkg::*;

    localparam int CW = $clog2(KEY_CODES);
    localparam int HW = $clog2(KEY_CODES + 1);
    localparam int XW = ((CW > 8) ? CW : 8) + 1;
    localparam logic [CW-1:0] CNT_LAST   = CW'(KEY_CODES - 1);
    localparam logic [XW-1:0] CODE_LIMIT = XW'(KEY_CODES);
    localparam logic [2:0]    SLOT_LIMIT = 3'(REPORT_KEYS);
    localparam logic [HW-1:0] ROLL_LIMIT = HW'(REPORT_KEYS);

    logic [KEY_CODES-1:0] r_map;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [HW-1:0]        r_held;
    logic [2:0]           r_slot;
    t_slots               r_slots;
    logic [7:0]           r_code;
    logic                 r_press;
    logic                 r_hit_en;

    logic       code_hit;
    logic       head_old;
    logic       head_new;
    logic       take_slot;
    logic [7:0] cnt_byte;

    // bit 0 of the map always holds the code that r_cnt names
    assign head_old  = r_map[0];
    assign code_hit  = r_hit_en && (XW'(r_code) < CODE_LIMIT) && (XW'(r_cnt) == XW'(r_code));
    assign head_new  = code_hit ? r_press : head_old;
    assign take_slot = r_busy && head_new && (r_slot < SLOT_LIMIT);
    assign cnt_byte  = 8'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_held <= '0;
            r_slot <= '0;
        end else if (i_ctl.clear) begin
            r_map  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_held <= '0;
            r_slot <= '0;
        end else if (i_ctl.start) begin
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_slot <= '0;
        end else if (r_busy) begin
            r_map <= {head_new, r_map[KEY_CODES-1:1]};
            if (code_hit && r_press && !head_old) begin
                r_held <= r_held + HW'(1);
            end else if (code_hit && !r_press && head_old) begin
                r_held <= r_held - HW'(1);
            end
            if (take_slot) begin
                r_slot <= r_slot + 3'd1;
            end
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear || i_ctl.start) begin
            r_slots  <= '0;
            r_code   <= i_ctl.code;
            r_press  <= i_ctl.press;
            r_hit_en <= i_ctl.hit_en && i_ctl.start;
        end else if (take_slot) begin
            r_slots[r_slot] <= cnt_byte;
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.rollover = r_held > ROLL_LIMIT;
    assign o_slots        = r_slots;

endmodule

// ===== rtl/hidrb_mouse.sv =====
// mouse state: button bits, modulo-256 delta sums, pending flag, tick count
// decides when a mouse report is due; uses hidrb_pkg

module hidrb_mouse (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  hidrb_pkg::t_mouse_ctl  i_ctl,
    input  logic [7:0]             i_interval,
    output hidrb_pkg::t_mouse_sts  o_sts
);
    import hidrb_pkg::*;

    logic [2:0] r_buttons;
    logic [7:0] r_sum_x;
    logic [7:0] r_sum_y;
    logic [7:0] r_sum_w;
    logic       r_pending;
    logic [7:0] r_ticks;
    logic [2:0] btn_bit;

    always_comb begin
        case (i_ctl.btn)
            BTN_LEFT:   btn_bit = 3'b001;
            BTN_RIGHT:  btn_bit = 3'b010;
            BTN_MIDDLE: btn_bit = 3'b100;
            default:    btn_bit = 3'b000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buttons <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_w   <= '0;
            r_pending <= 1'b0;
            r_ticks   <= TICK_MAX;
        end else begin
            if (i_ctl.clear) begin
                r_buttons <= '0;
                r_sum_x   <= '0;
                r_sum_y   <= '0;
                r_sum_w   <= '0;
            end
            if (i_ctl.motion) begin
                r_sum_x   <= r_sum_x + i_ctl.dx;
                r_sum_y   <= r_sum_y + i_ctl.dy;
                r_pending <= 1'b1;
            end
            if (i_ctl.button) begin
                r_buttons <= i_ctl.press ? (r_buttons | btn_bit) : (r_buttons & ~btn_bit);
                r_pending <= 1'b1;
            end
            if (i_ctl.wheel) begin
                r_sum_w   <= r_sum_w + i_ctl.dw;
                r_pending <= 1'b1;
            end
            if (i_ctl.tick && (r_ticks != TICK_MAX)) begin
                r_ticks <= r_ticks + 8'd1;
            end
            // report sent: sums restart and the interval count starts over
            if (i_ctl.emit) begin
                r_sum_x   <= '0;
                r_sum_y   <= '0;
                r_sum_w   <= '0;
                r_pending <= 1'b0;
                r_ticks   <= '0;
            end
        end
    end

    assign o_sts.want    = r_pending && (r_ticks > i_interval);
    assign o_sts.buttons = r_buttons;
    assign o_sts.sum_x   = r_sum_x;
    assign o_sts.sum_y   = r_sum_y;
    assign o_sts.sum_w   = r_sum_w;

endmodule

// ===== rtl/hid_report_builder.sv =====
// top level of the hid boot report builder: sequencer, modifiers, output register
// depends on hidrb_pkg, hidrb_key_scan and hidrb_mouse
//
// channel   direction  handshake            payload
// event     in         i_valid / o_ready    i_data (t_in)
// report    out        o_valid / i_ready    o_data (t_out)
// config    in         i_cfg_we             i_cfg_data (mouse interval ticks)
//
// a key event passes through the accepting cycle, one rotation of the held-key bitmap
// through its shift register, one code per cycle, a done cycle and the load of the
// report. motion, button, wheel and tick events pass through the check state; clear
// all loads a keyboard and then a mouse report; a due mouse report adds its load state.
// reset is synchronous and clears the bitmap, counters and state.
// a stalled report output holds the sequencer in its load state; an event is
// taken while the previous report still waits in the output register.

module hid_report_builder #(
    parameter int KEY_CODES   = 256,
    parameter int REPORT_KEYS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hidrb_pkg::t_in    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output hidrb_pkg::t_out   o_data,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data
);
    import hidrb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_KBD   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_MOUSE = 3'd4;
    localparam logic [2:0] S_CLR   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [7:0] r_interval;
    logic [7:0] r_mods;
    logic       r_out_valid;
    t_out       r_out, n_out;

    logic       in_xfer;
    logic       out_free;
    logic       load;
    logic       is_mod;
    logic [7:0] mod_bit;

    t_scan_ctl  scan_ctl;
    t_scan_sts  scan_sts;
    t_slots     slots;
    t_mouse_ctl mouse_ctl;
    t_mouse_sts mouse_sts;

    assign o_ready  = (r_state == S_IDLE);
    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign is_mod   = (i_data.scancode >= MOD_FIRST) && (i_data.scancode <= MOD_LAST);
    assign mod_bit  = 8'd1 << i_data.scancode[2:0];

    assign scan_ctl.start  = in_xfer && (i_data.kind == KIND_KEY);
    assign scan_ctl.clear  = in_xfer && (i_data.kind == KIND_CLEAR);
    assign scan_ctl.press  = i_data.pressed;
    assign scan_ctl.hit_en = !is_mod;
    assign scan_ctl.code   = i_data.scancode;

    assign mouse_ctl.motion = in_xfer && (i_data.kind == KIND_MOTION);
    assign mouse_ctl.button = in_xfer && (i_data.kind == KIND_BUTTON);
    assign mouse_ctl.wheel  = in_xfer && (i_data.kind == KIND_WHEEL);
    assign mouse_ctl.tick   = in_xfer && (i_data.kind == KIND_TICK);
    assign mouse_ctl.clear  = in_xfer && (i_data.kind == KIND_CLEAR);
    assign mouse_ctl.emit   = (r_state == S_MOUSE) && out_free;
    assign mouse_ctl.press  = i_data.pressed;
    assign mouse_ctl.btn    = i_data.button;
    assign mouse_ctl.dx     = i_data.motion_x[7:0];
    assign mouse_ctl.dy     = i_data.motion_y[7:0];
    assign mouse_ctl.dw     = i_data.wheel_y[7:0];

    hidrb_key_scan #(
        .KEY_CODES   (KEY_CODES),
        .REPORT_KEYS (REPORT_KEYS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .o_sts   (scan_sts),
        .o_slots (slots)
    );

    hidrb_mouse u_mouse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mouse_ctl),
        .i_interval (r_interval),
        .o_sts      (mouse_sts)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_data.kind) inside
                        KIND_KEY:   n_state = S_SCAN;
                        KIND_CLEAR: n_state = S_CLR;
                        KIND_MOTION, KIND_BUTTON, KIND_WHEEL, KIND_TICK: n_state = S_CHECK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_sts.done) begin
                    n_state = S_KBD;
                end
            end
            S_KBD: begin
                if (out_free) begin
                    n_state = mouse_sts.want ? S_MOUSE : S_IDLE;
                end
            end
            S_CHECK: begin
                n_state = mouse_sts.want ? S_MOUSE : S_IDLE;
            end
            S_MOUSE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                if (out_free) begin
                    n_state = S_MOUSE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign load = out_free && ((r_state == S_KBD) || (r_state == S_MOUSE) ||
                               (r_state == S_CLR));

    always_comb begin
        n_out = '0;
        if (r_state == S_MOUSE) begin
            n_out.report_type = RPT_MOUSE;
            n_out.last        = 1'b1;
            n_out.byte0       = {5'b0, mouse_sts.buttons};
            n_out.byte1       = mouse_sts.sum_x;
            n_out.byte2       = mouse_sts.sum_y;
            n_out.byte3       = mouse_sts.sum_w;
        end else begin
            // after clear all the mouse report always follows
            n_out.report_type = RPT_KBD;
            n_out.last        = (r_state == S_KBD) && !mouse_sts.want;
            n_out.byte0       = r_mods;
            if (scan_sts.rollover) begin
                n_out.byte2 = ROLLOVER_CODE;
                n_out.byte3 = ROLLOVER_CODE;
                n_out.byte4 = ROLLOVER_CODE;
                n_out.byte5 = ROLLOVER_CODE;
                n_out.byte6 = ROLLOVER_CODE;
                n_out.byte7 = ROLLOVER_CODE;
            end else begin
                n_out.byte2 = slots[0];
                n_out.byte3 = slots[1];
                n_out.byte4 = slots[2];
                n_out.byte5 = slots[3];
                n_out.byte6 = slots[4];
                n_out.byte7 = slots[5];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= INTERVAL_RESET;
            r_mods      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_interval <= i_cfg_data;
            end
            if (scan_ctl.clear) begin
                r_mods <= '0;
            end else if (scan_ctl.start && is_mod) begin
                r_mods <= i_data.pressed ? (r_mods | mod_bit) : (r_mods & ~mod_bit);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/hidrb_checker.sv =====
// port-level checks on the hid report builder, attached by bind
// depends on hidrb_pkg and the hid_report_builder ports

module hidrb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input hidrb_pkg::t_in    i_data,
    input logic              o_valid,
    input logic              i_ready,
    input hidrb_pkg::t_out   o_data,
    input logic              i_cfg_we,
    input logic [7:0]        i_cfg_data
);
    import hidrb_pkg::*;

    // a waiting report holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("report changed or dropped before transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("report valid right after reset");

    // a key event closes the input as the bitmap scan begins
    a_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_data.kind == KIND_KEY) |=> !o_ready)
        else $error("event taken during key scan");

    a_mouse_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.report_type == RPT_MOUSE) |->
            o_data.last && (o_data.byte0[7:3] == 5'd0) && (o_data.byte4 == 8'd0) &&
            (o_data.byte5 == 8'd0) && (o_data.byte6 == 8'd0) && (o_data.byte7 == 8'd0))
        else $error("malformed mouse report");

    a_kbd_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.report_type == RPT_KBD) |-> (o_data.byte1 == 8'd0))
        else $error("keyboard reserved byte not zero");

endmodule

bind hid_report_builder hidrb_checker u_hidrb_checker (.*);
